// ----- src/mbdec_pkg.sv -----
// ----------------------------------------------------------------------------
// mbdec_pkg
// Shared types, constants and controller/datapath interface structs for the
// multi-button debouncer with edge counters.
// ----------------------------------------------------------------------------
package mbdec_pkg;

  localparam int BUTTONS_DEF    = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int PORT_W         = 16;
  localparam int TIME_W         = 32;
  localparam int QUERY_W        = 4;
  localparam int SEL_W          = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODES    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 32'h0000_0000;
  localparam logic [CFG_DATA_W-1:0] MODES_RST    = 32'h5555_5555;

  // Per-button count modes.
  localparam logic [1:0] MODE_BOTH    = 2'd0;
  localparam logic [1:0] MODE_FALLING = 2'd1;
  localparam logic [1:0] MODE_RISING  = 2'd2;

  typedef struct packed {
    logic [PORT_W-1:0]  pin_levels;
    logic [TIME_W-1:0]  now_ms;
    logic [PORT_W-1:0]  clear_count_mask;
    logic [QUERY_W-1:0] query_button;
  } in_t;

  typedef struct packed {
    logic [PORT_W-1:0] steady_levels;
    logic [PORT_W-1:0] pressed_mask;
    logic [PORT_W-1:0] released_mask;
    logic [SEL_W-1:0]  selected_count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the input transaction, clear accumulators
    logic rd_en;     // read per-button memories at the walk index
    logic wb_en;     // update the button read in the previous cycle
    logic out_load;  // move the finished result into the output register
  } cmd_t;

endpackage

// ----- src/mbdec_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbdec_ctrl
// Controller: accepts a transaction, walks the buttons one per cycle through
// the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module mbdec_ctrl #(
  parameter int BUTTONS = mbdec_pkg::BUTTONS_DEF,
  parameter int IDX_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mbdec_pkg::cmd_t   cmd,
  output logic [IDX_W-1:0]  rd_idx
);
  import mbdec_pkg::*;

  localparam int CNT_W = $clog2(BUTTONS + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(BUTTONS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        // Read of button k overlaps the update of button k-1.
        cmd.rd_en = (cnt_r < LAST);
        cmd.wb_en = (cnt_r != '0);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign rd_idx    = cnt_r[IDX_W-1:0];
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while still holding a transaction");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (cnt_r < LAST))
    else $error("memory read beyond the last button");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_RUN && cnt_r == '0))
    else $error("accepted transaction did not start a walk at button zero");

  a_fin_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && $past(state_r) != ST_FIN) |-> $past(cnt_r) == LAST)
    else $error("walk ended before all buttons were updated");
`endif

endmodule

// ----- src/mbdec_dp.sv -----
// ----------------------------------------------------------------------------
// mbdec_dp
// Datapath: configuration registers, per-button level vectors, change-time
// and count memories, the per-button update and the output register.
// ----------------------------------------------------------------------------
module mbdec_dp #(
  parameter int BUTTONS    = mbdec_pkg::BUTTONS_DEF,
  parameter int COUNT_BITS = mbdec_pkg::COUNT_BITS_DEF,
  parameter int IDX_W      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mbdec_pkg::in_t                       in_data,
  output mbdec_pkg::out_t                      out_data,
  input  logic                                 cfg_we,
  input  logic [mbdec_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbdec_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  mbdec_pkg::cmd_t                      cmd,
  input  logic [IDX_W-1:0]                     rd_idx
);
  import mbdec_pkg::*;

  // Configuration.
  logic [TIME_W-1:0]     debounce_r;
  logic [CFG_DATA_W-1:0] modes_r;

  // Captured transaction.
  in_t in_r;

  // Per-button level state.
  logic [BUTTONS-1:0] raw_r, raw_nxt;
  logic [BUTTONS-1:0] steady_r, steady_nxt;
  logic [BUTTONS-1:0] prior_r, prior_nxt;
  logic [BUTTONS-1:0] pressed_r, pressed_nxt;
  logic [BUTTONS-1:0] released_r, released_nxt;
  logic [COUNT_BITS-1:0] sel_r, sel_nxt;

  // Change-time and count memories; an entry never written reads as zero.
  logic [TIME_W-1:0]     ct_mem [BUTTONS];
  logic [COUNT_BITS-1:0] ec_mem [BUTTONS];
  logic [BUTTONS-1:0]    vld_r;
  logic [TIME_W-1:0]     ct_rd_r;
  logic [COUNT_BITS-1:0] ec_rd_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      wb_idx_r;

  out_t out_r;

  // Update of one button.
  logic [TIME_W-1:0]     ct_q, ct_wr, elapsed;
  logic [COUNT_BITS-1:0] ec_q, ec_inc, ec_wr;
  logic                  cur, upd, prior_b, steady_b, falling, rising, count_en;
  logic [1:0]            mode;

  always_comb begin
    ct_q     = rd_vld_r ? ct_rd_r : '0;
    ec_q     = rd_vld_r ? ec_rd_r : '0;
    cur      = in_r.pin_levels[wb_idx_r];
    mode     = 2'(modes_r >> {wb_idx_r, 1'b0});
    ct_wr    = (cur != raw_r[wb_idx_r]) ? in_r.now_ms : ct_q;
    elapsed  = in_r.now_ms - ct_wr;
    upd      = (elapsed >= debounce_r);
    prior_b  = upd ? steady_r[wb_idx_r] : prior_r[wb_idx_r];
    steady_b = upd ? cur : steady_r[wb_idx_r];
    falling  = prior_b && !steady_b;
    rising   = !prior_b && steady_b;
    count_en = (prior_b != steady_b) &&
               ((mode == MODE_BOTH) || (mode == MODE_FALLING && falling) ||
                (mode == MODE_RISING && rising));
    ec_inc   = count_en ? (ec_q + 1'b1) : ec_q;
    ec_wr    = in_r.clear_count_mask[wb_idx_r] ? '0 : ec_inc;

    raw_nxt      = raw_r;
    steady_nxt   = steady_r;
    prior_nxt    = prior_r;
    pressed_nxt  = pressed_r;
    released_nxt = released_r;
    sel_nxt      = sel_r;
    if (cmd.load_in) begin
      pressed_nxt  = '0;
      released_nxt = '0;
      sel_nxt      = '0;
    end else if (cmd.wb_en) begin
      raw_nxt[wb_idx_r]      = cur;
      steady_nxt[wb_idx_r]   = steady_b;
      prior_nxt[wb_idx_r]    = prior_b;
      pressed_nxt[wb_idx_r]  = falling;
      released_nxt[wb_idx_r] = rising;
      // The reported count is taken before the clear is applied.
      if (in_r.query_button == QUERY_W'(wb_idx_r)) begin
        sel_nxt = ec_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      modes_r    <= MODES_RST;
      raw_r      <= '1;
      steady_r   <= '1;
      prior_r    <= '1;
      vld_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: debounce_r <= cfg_wdata;
          REG_MODES:    modes_r    <= cfg_wdata;
          default:      ;
        endcase
      end
      raw_r    <= raw_nxt;
      steady_r <= steady_nxt;
      prior_r  <= prior_nxt;
      if (cmd.wb_en) begin
        vld_r[wb_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    pressed_r  <= pressed_nxt;
    released_r <= released_nxt;
    sel_r      <= sel_nxt;
    if (cmd.rd_en) begin
      ct_rd_r  <= ct_mem[rd_idx];
      ec_rd_r  <= ec_mem[rd_idx];
      rd_vld_r <= vld_r[rd_idx];
      wb_idx_r <= rd_idx;
    end
    if (cmd.wb_en) begin
      ct_mem[wb_idx_r] <= ct_wr;
      ec_mem[wb_idx_r] <= ec_wr;
    end
    if (cmd.out_load) begin
      out_r.steady_levels  <= PORT_W'(steady_r);
      out_r.pressed_mask   <= PORT_W'(pressed_r);
      out_r.released_mask  <= PORT_W'(released_r);
      out_r.selected_count <= SEL_W'(sel_r);
    end
  end

  assign out_data = out_r;

endmodule

// ----- src/multi_button_debounce_edge_counter.sv -----
// ----------------------------------------------------------------------------
// multi_button_debounce_edge_counter
// Debounces an active-low button port sampled with a millisecond timestamp
// and keeps a wrapping edge count per button, filtered by a per-button mode.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    mbdec_pkg::in_t (one sample)
//   out_      output     out_valid/out_ready  mbdec_pkg::out_t (one result)
//   cfg_      input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// A new transaction is accepted only in the idle state, once the walk over
// the buttons for the previous one has finished and its result has been
// loaded into the output register. During the walk the change-time and count
// memories are read and written back one button per cycle, with the read of
// the next button overlapping the update of the current one. Reset is
// synchronous and active low; it restores the configuration registers and
// the level vectors and invalidates all memory entries at once, so no
// clearing pass is needed. A stalled result sits in the output register
// while the next transaction is accepted and walked; only the hand-over of
// that next result waits for out_ready.
//
module multi_button_debounce_edge_counter #(
  parameter int BUTTONS    = mbdec_pkg::BUTTONS_DEF,
  parameter int COUNT_BITS = mbdec_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mbdec_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mbdec_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [mbdec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbdec_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mbdec_pkg::*;

  // Width of a button index; at least one bit even for a single button.
  localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  cmd_t             cmd;
  logic [IDX_W-1:0] rd_idx;

  // The controller sequences acceptance, the per-button walk and the result
  // hand-over; it owns the output valid flag.
  mbdec_ctrl #(
    .BUTTONS (BUTTONS),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .rd_idx    (rd_idx)
  );

  // The datapath holds all per-button state and performs the debounce test,
  // the steady-level shift and the count update for one button per cycle.
  mbdec_dp #(
    .BUTTONS    (BUTTONS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rd_idx    (rd_idx)
  );

endmodule
